// File: rtl/core/ihrc_pkg.sv
// Shared types and constants for the IPv4 header receive check.
// Used by the front parser, the verdict queue, the back end and the top level.
package ihrc_pkg;

  localparam int unsigned MIN_HEADER      = 20;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NET_MASK   = 2'd1;

  localparam logic [15:0] FRAG_MASK    = 16'h3fff;
  localparam logic [15:0] SUM_GOOD     = 16'hffff;
  localparam logic [15:0] COUNT_MAX    = 16'hffff;
  localparam logic [3:0]  IP_VERSION_4 = 4'd4;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_VER_FRAG = 3'd2,
    VERDICT_LENGTH   = 3'd3,
    VERDICT_NOT_OURS = 3'd4,
    VERDICT_CHECKSUM = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  header_len;
    logic [15:0] total_len;
  } out_item_t;

  // Per-frame summary handed from the parser to the verdict stage.
  typedef struct packed {
    logic [15:0] size;
    logic [20:0] sum;
    logic [7:0]  ver_ihl;
    logic [15:0] len_field;
    logic [15:0] frag_field;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

// File: rtl/core/ihrc_front.sv
// Front parser: counts bytes, captures header fields, keeps the header sum.
// Pushes one frame summary per last byte. Depends on ihrc_pkg.
module ihrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ihrc_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                push,
  output ihrc_pkg::frame_rec_t rec
);
  import ihrc_pkg::*;

  logic [15:0] byte_count, byte_count_next;
  logic [20:0] sum_acc, sum_acc_next;
  logic [7:0]  pending_high, pending_high_next;
  logic [7:0]  ver_ihl, ver_ihl_next;
  logic [15:0] len_field, len_field_next;
  logic [15:0] frag_field, frag_field_next;
  logic [7:0]  proto_reg, proto_reg_next;
  logic [31:0] src_reg, src_reg_next;
  logic [31:0] dst_reg, dst_reg_next;
  logic [5:0]  hdr_len;
  logic        accept;
  logic [7:0]  b;

  assign accept = in_valid && !q_full;
  assign b      = in_data.data_byte;
  assign push   = accept && in_data.last_byte;

  always_comb begin
    ver_ihl_next    = ver_ihl;
    len_field_next  = len_field;
    frag_field_next = frag_field;
    proto_reg_next  = proto_reg;
    src_reg_next    = src_reg;
    dst_reg_next    = dst_reg;
    case (byte_count)
      16'd0: ver_ihl_next = b;
      16'd2: len_field_next = {b, len_field[7:0]};
      16'd3: len_field_next = {len_field[15:8], b};
      16'd6: frag_field_next = {b, frag_field[7:0]};
      16'd7: frag_field_next = {frag_field[15:8], b};
      16'd9: proto_reg_next = b;
      16'd12, 16'd13, 16'd14, 16'd15: src_reg_next = {src_reg[23:0], b};
      16'd16, 16'd17, 16'd18, 16'd19: dst_reg_next = {dst_reg[23:0], b};
      default: ;
    endcase

    hdr_len           = {ver_ihl_next[3:0], 2'b00};
    pending_high_next = pending_high;
    sum_acc_next      = sum_acc;
    if (byte_count < {10'd0, hdr_len}) begin
      if (!byte_count[0]) begin
        pending_high_next = b;
      end else begin
        sum_acc_next = sum_acc + {5'd0, pending_high, b};
      end
    end

    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 16'd1 : byte_count;
  end

  always_comb begin
    rec.size       = byte_count_next;
    rec.sum        = sum_acc_next;
    rec.ver_ihl    = ver_ihl_next;
    rec.len_field  = len_field_next;
    rec.frag_field = frag_field_next;
    rec.proto      = proto_reg_next;
    rec.src        = src_reg_next;
    rec.dst        = dst_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count   <= '0;
      sum_acc      <= '0;
      pending_high <= '0;
      ver_ihl      <= '0;
      len_field    <= '0;
      frag_field   <= '0;
      proto_reg    <= '0;
      src_reg      <= '0;
      dst_reg      <= '0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      sum_acc      <= sum_acc_next;
      pending_high <= pending_high_next;
      ver_ihl      <= ver_ihl_next;
      len_field    <= len_field_next;
      frag_field   <= frag_field_next;
      proto_reg    <= proto_reg_next;
      src_reg      <= src_reg_next;
      dst_reg      <= dst_reg_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (byte_count == 16'd0) && (sum_acc == 21'd0))
    else $error("frame state not cleared after last byte");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_data.last_byte && byte_count != COUNT_MAX)
      |=> byte_count == $past(byte_count) + 16'd1)
    else $error("byte count did not advance");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(byte_count) && $stable(sum_acc))
    else $error("frame state changed without a byte");
`endif

endmodule

// File: rtl/core/ihrc_queue.sv
// Short queue of frame summaries between the parser and the verdict stage.
// Depends on ihrc_pkg for the record type.
module ihrc_queue #(
  parameter int unsigned Depth = ihrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ihrc_pkg::frame_rec_t   wr_rec,
  input  logic                   pop,
  output ihrc_pkg::frame_rec_t   rd_rec,
  output ihrc_pkg::queue_status_t status
);
  import ihrc_pkg::*;

  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]   PtrLast  = PtrW'(Depth - 1);
  localparam logic [CountW-1:0] CountMax = CountW'(Depth);

  frame_rec_t        entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign status = '{full: (count == CountMax), not_empty: (count != '0)};
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/ihrc_back.sv
// Verdict stage: runs the ordered checks on a frame summary and holds the result.
// Depends on ihrc_pkg for record, result and verdict types.
module ihrc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          local_addr,
  input  logic [31:0]          net_mask,
  input  ihrc_pkg::frame_rec_t rec,
  input  logic                 rec_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihrc_pkg::out_item_t  out_data
);
  import ihrc_pkg::*;

  logic [5:0]  hdr;
  logic [16:0] fold1, fold2;
  logic [31:0] net_addr, bcast_addr;
  logic        dest_ok;
  verdict_t    verdict;

  assign pop = rec_valid && (!out_valid || !out_stall);

  always_comb begin
    hdr        = {rec.ver_ihl[3:0], 2'b00};
    fold1      = {12'd0, rec.sum[20:16]} + {1'b0, rec.sum[15:0]};
    fold2      = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
    net_addr   = local_addr & net_mask;
    bcast_addr = local_addr | ~net_mask;
    dest_ok    = (local_addr == '0) || (rec.dst == local_addr) || (rec.dst == '0) ||
                 (rec.dst == '1) || (rec.dst == net_addr) || (rec.dst == bcast_addr);

    if (rec.size < 16'(MIN_HEADER)) begin
      verdict = VERDICT_SHORT;
    end else if (rec.ver_ihl[7:4] != IP_VERSION_4 || (rec.frag_field & FRAG_MASK) != '0) begin
      verdict = VERDICT_VER_FRAG;
    end else if (hdr < 6'(MIN_HEADER) || {10'd0, hdr} > rec.len_field ||
                 rec.len_field > rec.size) begin
      verdict = VERDICT_LENGTH;
    end else if (!dest_ok) begin
      verdict = VERDICT_NOT_OURS;
    end else if (fold2 != {1'b0, SUM_GOOD}) begin
      verdict = VERDICT_CHECKSUM;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.verdict    <= verdict;
      out_data.protocol   <= rec.proto;
      out_data.src_addr   <= rec.src;
      out_data.dst_addr   <= rec.dst;
      out_data.header_len <= hdr;
      out_data.total_len  <= rec.len_field;
    end
  end

endmodule

// File: rtl/core/ipv4_header_receive_check.sv
// IPv4 header receive check: one packet byte per cycle, one verdict per frame.
// Throughput: one byte accepted every cycle; stall rises only while the
// verdict queue (QueueDepth frames) is full behind a stalled output.
// Summaries go through the verdict queue; the verdict stage registers verdicts.
// Reset (synchronous, rst high) clears frame state, queue, output valid and
// both address registers; no clearing pass is needed.
module ipv4_header_receive_check #(
  parameter int unsigned QueueDepth = ihrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ihrc_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ihrc_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [ihrc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ihrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ihrc_pkg::*;

  logic [31:0]   local_addr;
  logic [31:0]   net_mask;
  logic          push;
  logic          pop;
  frame_rec_t    wr_rec;
  frame_rec_t    rd_rec;
  queue_status_t q_status;

  assign in_stall = q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
      net_mask   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDR: local_addr <= cfg_data;
        CFG_NET_MASK:   net_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  ihrc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_data (in_data),
    .q_full  (q_status.full),
    .push    (push),
    .rec     (wr_rec)
  );

  ihrc_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_rec(wr_rec),
    .pop   (pop),
    .rd_rec(rd_rec),
    .status(q_status)
  );

  ihrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .local_addr(local_addr),
    .net_mask  (net_mask),
    .rec       (rd_rec),
    .rec_valid (q_status.not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/ipv4_header_receive_check_tb.sv
// Self-checking bench for ipv4_header_receive_check: byte streams in, one verdict per frame out.
// Keeps its own model of the parser and filter; needs ihrc_pkg and the block's RTL only.
module ipv4_header_receive_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihrc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_BYTES   = 700;
  localparam int unsigned RANDOM_FRAMES  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ipv4_header_receive_check dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Model of the filter: address registers and per-frame capture state.
  logic [31:0] my_addr, my_mask;
  logic [15:0] bytes_seen;
  logic [20:0] word_sum;
  logic [7:0]  hi_byte, vihl, proto_b;
  logic [15:0] tot_len, frag_word;
  logic [31:0] src_ip, dst_ip;

  out_item_t   verdict_q[$];
  logic [7:0]  frame_buf[$];

  int unsigned errors, results_seen, bytes_sent, frames_sent, reg_writes;
  int unsigned verdict_hits[6];
  int unsigned stall_cnt, idle_cycles;
  bit          no_idle;

  function automatic void restart_frame();
    bytes_seen = '0;
    word_sum   = '0;
    hi_byte    = '0;
    vihl       = '0;
    tot_len    = '0;
    frag_word  = '0;
    proto_b    = '0;
    src_ip     = '0;
    dst_ip     = '0;
  endfunction

  function automatic bit dest_accepted(logic [31:0] d);
    if (my_addr == '0) return 1'b1;
    return d == my_addr || d == '0 || d == 32'hffffffff ||
           d == (my_addr & my_mask) || d == (my_addr | ~my_mask);
  endfunction

  function automatic verdict_t classify();
    int unsigned hb, folded;
    hb = vihl[3:0] * 4;
    if (bytes_seen < MIN_HEADER) return VERDICT_SHORT;
    if (vihl[7:4] != IP_VERSION_4 || (frag_word & FRAG_MASK) != '0) return VERDICT_VER_FRAG;
    if (hb < MIN_HEADER || hb > tot_len || tot_len > bytes_seen) return VERDICT_LENGTH;
    if (!dest_accepted(dst_ip)) return VERDICT_NOT_OURS;
    folded = word_sum[20:16] + word_sum[15:0];
    folded = (folded >> 16) + (folded & 32'hffff);
    if (folded != SUM_GOOD) return VERDICT_CHECKSUM;
    return VERDICT_ACCEPT;
  endfunction

  function automatic void absorb_byte(in_item_t w);
    logic [15:0] idx;
    out_item_t   e;
    idx = bytes_seen;
    case (idx)
      16'd0: vihl = w.data_byte;
      16'd2: tot_len[15:8] = w.data_byte;
      16'd3: tot_len[7:0] = w.data_byte;
      16'd6: frag_word[15:8] = w.data_byte;
      16'd7: frag_word[7:0] = w.data_byte;
      16'd9: proto_b = w.data_byte;
      16'd12, 16'd13, 16'd14, 16'd15: src_ip = {src_ip[23:0], w.data_byte};
      16'd16, 16'd17, 16'd18, 16'd19: dst_ip = {dst_ip[23:0], w.data_byte};
      default: ;
    endcase
    // only header words enter the checksum
    if (idx < {vihl[3:0], 2'b00}) begin
      if (!idx[0]) hi_byte = w.data_byte;
      else word_sum = word_sum + {hi_byte, w.data_byte};
    end
    if (bytes_seen != COUNT_MAX) bytes_seen = bytes_seen + 16'd1;
    if (w.last_byte) begin
      e.verdict    = classify();
      e.protocol   = proto_b;
      e.src_addr   = src_ip;
      e.dst_addr   = dst_ip;
      e.header_len = {vihl[3:0], 2'b00};
      e.total_len  = tot_len;
      verdict_q.push_back(e);
      restart_frame();
    end
  endfunction

  function automatic void compare_field(string fld, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, want, seen);
    end
  endfunction

  function automatic void check_verdict(out_item_t got);
    out_item_t e;
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: verdict word with nothing expected: expected none, actual %h", $time, got);
      return;
    end
    e = verdict_q.pop_front();
    results_seen++;
    verdict_hits[int'(e.verdict)]++;
    compare_field("verdict", 32'(e.verdict), 32'(got.verdict));
    compare_field("protocol", 32'(e.protocol), 32'(got.protocol));
    compare_field("src_addr", e.src_addr, got.src_addr);
    compare_field("dst_addr", e.dst_addr, got.dst_addr);
    compare_field("header_len", 32'(e.header_len), 32'(got.header_len));
    compare_field("total_len", 32'(e.total_len), 32'(got.total_len));
  endfunction

  // Model update and checking, all on the edge that moves each word.
  always @(posedge clk) begin
    if (rst) begin
      my_addr = '0;
      my_mask = '0;
      restart_frame();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_ADDR: my_addr = cfg_data;
          CFG_NET_MASK:   my_mask = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_byte(in_data);
      if (out_valid && !out_stall) check_verdict(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // Hold off the next verdict word for a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      stall_cnt = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_cnt = draw_wait();
      else if (stall_cnt != 0) stall_cnt--;
      out_stall <= (stall_cnt != 0);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    int unsigned gap;
    logic [31:0] junk;
    gap = draw_wait();
    if (gap != 0) begin
      junk = $urandom;
      in_valid <= 1'b0;
      in_data  <= junk[8:0];
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: is_last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
    bytes_sent += frame_buf.size();
  endtask

  // Build a header with a correct (or one-bit-off) checksum, then pad or cut to flen bytes.
  task automatic send_packet(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tlen, input logic [15:0] frag,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input bit good_sum,
                             input int unsigned flen, input int fill);
    int unsigned hbytes, span, acc;
    logic [15:0] csum;
    hbytes = ihl * 4;
    span = (hbytes > 20) ? hbytes : 20;
    frame_buf.delete();
    for (int i = 0; i < span; i++) frame_buf.push_back(8'($urandom));
    frame_buf[0]  = {ver, ihl};
    frame_buf[2]  = tlen[15:8];
    frame_buf[3]  = tlen[7:0];
    frame_buf[6]  = frag[15:8];
    frame_buf[7]  = frag[7:0];
    frame_buf[9]  = proto;
    frame_buf[10] = 8'h00;
    frame_buf[11] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      frame_buf[12 + i] = src[31 - 8*i -: 8];
      frame_buf[16 + i] = dst[31 - 8*i -: 8];
    end
    acc = 0;
    for (int i = 0; i + 1 < hbytes; i += 2) acc += {frame_buf[i], frame_buf[i+1]};
    while ((acc >> 16) != 0) acc = (acc & 32'hffff) + (acc >> 16);
    csum = ~acc[15:0];
    if (!good_sum) csum = csum ^ (16'd1 << $urandom_range(0, 15));
    frame_buf[10] = csum[15:8];
    frame_buf[11] = csum[7:0];
    while (frame_buf.size() < flen) frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    while (frame_buf.size() > flen) void'(frame_buf.pop_back());
    send_frame();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Wait for every verdict owed, then let the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_dst();
    case ($urandom_range(0, 6))
      0: return my_addr;
      1: return 32'h0;
      2: return 32'hffffffff;
      3: return my_addr & my_mask;
      4: return my_addr | ~my_mask;
      5: return my_addr ^ (32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_defaults_accept_all();
    // address registers are zero after reset: any destination passes
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'h00, 32'h0, $urandom, 1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd24, 16'h0000, 8'hff, 32'hffffffff, 32'hffffffff,
                1'b1, 24, 255);
    send_packet(IP_VERSION_4, 4'd5, 16'd22, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 22, 0);
    // lone byte: nothing past the version byte is captured
    frame_buf.delete();
    frame_buf.push_back(8'hff);
    send_frame();
    // cut inside the source address
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 14, -1);
  endtask

  task automatic test_header_rejects();
    send_packet(4'd6, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h2000, 8'($urandom), $urandom, $urandom,
                1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0001, 8'($urandom), $urandom, $urandom,
                1'b1, 20, -1);
    // don't-fragment alone is not a fragment
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h4000, 8'($urandom), $urandom, $urandom,
                1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd4, 16'd20, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd6, 16'd22, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 24, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd40, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 30, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b0, 20, -1);
    // trailing bytes past total length are allowed
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 26, -1);
    send_packet(IP_VERSION_4, 4'd15, 16'd60, 16'h0000, 8'($urandom), $urandom, $urandom,
                1'b1, 60, -1);
  endtask

  task automatic test_destination_filter();
    logic [31:0] host;
    logic [31:0] ok_dst[5];
    host = {8'd10, 24'($urandom)};
    drain_results();
    write_reg(CFG_LOCAL_ADDR, host);
    write_reg(CFG_NET_MASK, 32'hffffff00);
    ok_dst = '{host, 32'h0, 32'hffffffff, host & 32'hffffff00, host | 32'h000000ff};
    foreach (ok_dst[i])
      send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, ok_dst[i],
                  1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, host ^ 32'h100,
                1'b1, 20, -1);
    // address check ranks above the checksum
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, host ^ 32'h100,
                1'b0, 20, -1);
  endtask

  task automatic test_spare_registers();
    // writes to unused indexes must leave the filter as it was
    drain_results();
    write_reg(CFG_SPARE_2, 32'h0);
    write_reg(CFG_SPARE_3, $urandom);
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom,
                my_addr ^ 32'h100, 1'b1, 20, -1);
    send_packet(IP_VERSION_4, 4'd5, 16'd20, 16'h0000, 8'($urandom), $urandom, my_addr,
                1'b1, 20, -1);
  endtask

  task automatic random_frame();
    logic [3:0]  ver, ihl;
    logic [15:0] tlen, frag;
    int unsigned flen, pay, pick, n;
    int          fill;
    bit          good;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      frame_buf.delete();
      n = $urandom_range(1, 40);
      repeat (n) frame_buf.push_back(8'($urandom));
      send_frame();
      return;
    end
    ver  = IP_VERSION_4;
    ihl  = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    pay  = $urandom_range(0, 16);
    tlen = 16'(ihl * 4 + pay);
    frag = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
    good = 1'b1;
    flen = 32'(tlen);
    fill = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 255 : 0) : -1;
    if ($urandom_range(0, 3) == 0) flen += $urandom_range(1, 4);
    // break one thing in about a third of the well-formed frames
    if (pick >= 70) begin
      case ($urandom_range(0, 6))
        0: ver = ver ^ 4'($urandom_range(1, 15));
        1: frag = {2'($urandom), 14'($urandom_range(1, 16383))};
        2: ihl = 4'($urandom_range(0, 4));
        3: tlen = 16'($urandom);
        4: flen = $urandom_range(1, 19);
        5: flen = (tlen > 20) ? $urandom_range(20, tlen - 1) : 19;
        default: good = 1'b0;
      endcase
    end
    send_packet(ver, ihl, tlen, frag, 8'($urandom), $urandom, pick_dst(), good, flen, fill);
  endtask

  task automatic test_random_traffic();
    int unsigned phase, b0, f0, budget;
    phase = 0;
    b0 = bytes_sent;
    f0 = frames_sent;
    while ((bytes_sent - b0) < RANDOM_BYTES || (frames_sent - f0) < RANDOM_FRAMES) begin
      drain_results();
      case (phase % 6)
        0: begin write_reg(CFG_LOCAL_ADDR, 32'h0); write_reg(CFG_NET_MASK, $urandom); end
        1: begin write_reg(CFG_LOCAL_ADDR, $urandom); write_reg(CFG_NET_MASK, 32'hffffff00); end
        2: begin write_reg(CFG_LOCAL_ADDR, 32'hffffffff); write_reg(CFG_NET_MASK, 32'hffffffff); end
        3: begin write_reg(CFG_LOCAL_ADDR, $urandom); write_reg(CFG_NET_MASK, 32'h0); end
        4: begin write_reg(CFG_LOCAL_ADDR, $urandom); write_reg(CFG_NET_MASK, $urandom); end
        default: begin write_reg(CFG_LOCAL_ADDR, 32'h1); write_reg(CFG_NET_MASK, 32'hffffffff); end
      endcase
      // every third phase runs back to back on both sides
      no_idle = (phase % 3 == 2);
      budget = bytes_sent + 100;
      while (bytes_sent < budget) random_frame();
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_defaults_accept_all();
    test_header_rejects();
    test_destination_filter();
    test_spare_registers();
    test_random_traffic();
    drain_results();
    $display("Covered %0d frames (%0d bytes), %0d register writes, %0d verdicts checked.",
             frames_sent, bytes_sent, reg_writes, results_seen);
    $display("Verdicts: accept %0d, short %0d, ver/frag %0d, length %0d, not ours %0d, sum %0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
             verdict_hits[4], verdict_hits[5]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
